// File: hdl/ifr_pkg.sv
// ============================================================================
// ifr_pkg
// Shared types and constants of the info frame receiver.
// ============================================================================
package ifr_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int COUNT_W     = 11;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLAG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1 = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;
    localparam logic [1:0] KIND_LENGTH  = 2'd3;

    // Receiver phases
    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_GOT_FLAG = 3'd1;
    localparam logic [2:0] PH_GOT_ADDR = 3'd2;
    localparam logic [2:0] PH_GOT_CTRL = 3'd3;
    localparam logic [2:0] PH_DATA     = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_PAYLOAD);

    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
        logic [7:0] address_value;
        logic [7:0] control_seq_zero;
        logic [7:0] control_seq_one;
    } ifr_cfg_t;

    // One classified line byte. Matches that depend on the sequence bit are
    // given for both values so the back end picks the one it needs.
    typedef struct packed {
        logic [7:0] data;
        logic       is_flag;
        logic       is_escape;
        logic       is_address;
        logic [1:0] ctrl_hit;
        logic [1:0] hcheck_hit;
    } ifr_token_t;

endpackage

// File: hdl/ifr_front.sv
// ============================================================================
// ifr_front
// Accepts line bytes and classifies them against the configured codes.
// ============================================================================
module ifr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ifr_pkg::ifr_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          line_byte,
    input  logic                queue_full,
    output logic                push,
    output ifr_pkg::ifr_token_t token
);
    import ifr_pkg::*;

    logic [7:0] hcheck0;
    logic [7:0] hcheck1;
    logic [15:0] accepted_reg;
    logic [15:0] accepted_next;

    assign hcheck0 = cfg.address_value ^ cfg.control_seq_zero;
    assign hcheck1 = cfg.address_value ^ cfg.control_seq_one;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        token.data          = line_byte;
        token.is_flag       = (line_byte == cfg.flag_value);
        token.is_escape     = (line_byte == cfg.escape_value);
        token.is_address    = (line_byte == cfg.address_value);
        token.ctrl_hit[0]   = (line_byte == cfg.control_seq_zero);
        token.ctrl_hit[1]   = (line_byte == cfg.control_seq_one);
        token.hcheck_hit[0] = (line_byte == hcheck0);
        token.hcheck_hit[1] = (line_byte == hcheck1);
    end

    // Free-running count of accepted bytes, kept for the assertions below.
    assign accepted_next = accepted_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= '0;
        end
        else if (push)
        begin
            accepted_reg <= accepted_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push)
        else $error("byte accepted while the queue is full");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> accepted_reg == $past(accepted_next))
        else $error("accepted byte count did not advance");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !push |=> $stable(accepted_reg))
        else $error("accepted byte count moved without a transaction");

endmodule

// File: hdl/ifr_queue.sv
// ============================================================================
// ifr_queue
// Two-entry queue of classified bytes between the front and back ends.
// ============================================================================
module ifr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ifr_pkg::ifr_token_t push_token,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ifr_pkg::ifr_token_t head_token
);
    import ifr_pkg::*;

    ifr_token_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_token = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill count out of range");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

// File: hdl/ifr_back.sv
// ============================================================================
// ifr_back
// Frame state machine: header hunt, un-escaping, check and verdicts.
// ============================================================================
module ifr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  ifr_pkg::ifr_token_t          head_token,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [7:0]                   payload_byte,
    output logic                         sequence_bit,
    output logic [ifr_pkg::COUNT_W-1:0]  payload_count
);
    import ifr_pkg::*;

    logic [2:0]         phase_reg;
    logic [2:0]         phase_next;
    logic               esc_reg;
    logic               esc_next;
    logic [7:0]         held_reg;
    logic [7:0]         held_next;
    logic               held_valid_reg;
    logic               held_valid_next;
    logic [7:0]         check_reg;
    logic [7:0]         check_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               seq_reg;
    logic               seq_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         kind_reg;
    logic [1:0]         kind_next;
    logic [7:0]         byte_reg;
    logic [7:0]         byte_next;
    logic               oseq_reg;
    logic               oseq_next;
    logic [COUNT_W-1:0] ocount_reg;
    logic [COUNT_W-1:0] ocount_next;

    logic               produce;
    logic [7:0]         value;
    logic [COUNT_W-1:0] count_inc;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign value     = esc_reg ? (head_token.data ^ ESC_XOR) : head_token.data;
    assign count_inc = count_reg + COUNT_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        check_next      = check_reg;
        count_next      = count_reg;
        seq_next        = seq_reg;
        produce         = 1'b0;
        kind_next       = kind_reg;
        byte_next       = byte_reg;
        oseq_next       = oseq_reg;
        ocount_next     = ocount_reg;

        if (pop)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (head_token.is_flag)
                    begin
                        phase_next = PH_GOT_FLAG;
                    end
                end
                PH_GOT_FLAG:
                begin
                    if (head_token.is_address)
                    begin
                        phase_next = PH_GOT_ADDR;
                    end
                    else if (!head_token.is_flag)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_GOT_ADDR:
                begin
                    if (head_token.ctrl_hit[seq_reg])
                    begin
                        phase_next = PH_GOT_CTRL;
                    end
                    else if (head_token.is_flag)
                    begin
                        phase_next = PH_GOT_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_GOT_CTRL:
                begin
                    if (head_token.hcheck_hit[seq_reg])
                    begin
                        phase_next      = PH_DATA;
                        esc_next        = 1'b0;
                        held_next       = ZERO_BYTE;
                        held_valid_next = 1'b0;
                        check_next      = ZERO_BYTE;
                        count_next      = '0;
                    end
                    else if (head_token.is_flag)
                    begin
                        phase_next = PH_GOT_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (head_token.is_flag)
                    begin
                        // Closing flag: a pending escape is dropped.
                        produce     = 1'b1;
                        byte_next   = ZERO_BYTE;
                        oseq_next   = seq_reg;
                        ocount_next = count_reg;
                        if (!held_valid_reg)
                        begin
                            kind_next = KIND_LENGTH;
                        end
                        else if (held_reg == check_reg)
                        begin
                            kind_next = KIND_ACCEPT;
                            seq_next  = !seq_reg;
                        end
                        else
                        begin
                            kind_next = KIND_REJECT;
                        end
                        phase_next      = PH_HUNT;
                        esc_next        = 1'b0;
                        held_next       = ZERO_BYTE;
                        held_valid_next = 1'b0;
                        check_next      = ZERO_BYTE;
                        count_next      = '0;
                    end
                    else if (!esc_reg && head_token.is_escape)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                        if (!held_valid_reg)
                        begin
                            held_next       = value;
                            held_valid_next = 1'b1;
                        end
                        else if (count_reg >= COUNT_LIMIT)
                        begin
                            produce         = 1'b1;
                            kind_next       = KIND_LENGTH;
                            byte_next       = ZERO_BYTE;
                            oseq_next       = seq_reg;
                            ocount_next     = count_reg;
                            phase_next      = PH_HUNT;
                            held_next       = ZERO_BYTE;
                            held_valid_next = 1'b0;
                            check_next      = ZERO_BYTE;
                            count_next      = '0;
                        end
                        else
                        begin
                            produce     = 1'b1;
                            kind_next   = KIND_PAYLOAD;
                            byte_next   = held_reg;
                            oseq_next   = seq_reg;
                            ocount_next = count_inc;
                            check_next  = check_reg ^ held_reg;
                            count_next  = count_inc;
                            held_next   = value;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            esc_reg        <= 1'b0;
            held_reg       <= ZERO_BYTE;
            held_valid_reg <= 1'b0;
            check_reg      <= ZERO_BYTE;
            count_reg      <= '0;
            seq_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            check_reg      <= check_next;
            count_reg      <= count_next;
            seq_reg        <= seq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        oseq_reg   <= oseq_next;
        ocount_reg <= ocount_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign payload_byte  = byte_reg;
    assign sequence_bit  = oseq_reg;
    assign payload_count = ocount_reg;

    a_held_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid_reg || esc_reg) |-> (phase_reg == PH_DATA))
        else $error("frame state live outside the payload phase");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("payload count beyond the frame limit");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_PAYLOAD)) |-> (ocount_reg != '0))
        else $error("payload byte delivered with a zero count");

    a_seq_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != $past(seq_reg)) |->
            (out_valid_reg && (kind_reg == KIND_ACCEPT)))
        else $error("sequence changed without an accepted frame");

endmodule

// File: hdl/info_frame_receiver.sv
// ============================================================================
// info_frame_receiver
// Receive side of a byte-stuffed framing link: header hunt, un-escaping,
// one-byte-late payload delivery and frame check verdicts.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   --------------------   -------------------------------------------
//  input     in_valid / in_ready    line_byte
//  output    out_valid / out_ready  kind, payload_byte, sequence_bit,
//                                   payload_count
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One line byte is taken per cycle while the queue has room; each byte gives
// at most one result transaction. Accepted bytes pass through the classifier
// queue; the frame state machine acts on each as it leaves and registers any
// result. The sustained rate is one byte per cycle while out_ready stays high.
// Reset brings the control and configuration registers (not the result fields
// or queue slots) to their defaults and the receiver to hunting for an opening
// flag. A stalled output holds the result and the back end stops; the front
// end keeps taking bytes until its two-entry queue fills.
//
module info_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      line_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [7:0]                      payload_byte,
    output logic                            sequence_bit,
    output logic [ifr_pkg::COUNT_W-1:0]     payload_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ifr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import ifr_pkg::*;

    // Configuration registers. Unenforced: the user must write only while the
    // receiver is idle, so no byte in flight sees a half-updated set of codes.
    ifr_cfg_t   cfg_reg;
    ifr_cfg_t   cfg_next;

    // Front end to queue, and queue to back end.
    ifr_token_t front_token;
    logic       front_push;
    logic       queue_full;
    ifr_token_t head_token;
    logic       head_valid;
    logic       back_pop;

    // The configuration channel never stalls.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FLAG:  cfg_next.flag_value       = cfg_data;
                REG_ESC:   cfg_next.escape_value     = cfg_data;
                REG_ADDR:  cfg_next.address_value    = cfg_data;
                REG_CTRL0: cfg_next.control_seq_zero = cfg_data;
                REG_CTRL1: cfg_next.control_seq_one  = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value       <= 8'h7E;
            cfg_reg.escape_value     <= 8'h7D;
            cfg_reg.address_value    <= 8'h03;
            cfg_reg.control_seq_zero <= 8'h00;
            cfg_reg.control_seq_one  <= 8'h40;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: takes a line byte whenever the queue has room and tags it
    // with every compare the state machine may need.
    ifr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .line_byte  (line_byte),
        .queue_full (queue_full),
        .push       (front_push),
        .token      (front_token)
    );

    // Two entries decouple the input handshake from output back-pressure.
    ifr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_token (front_token),
        .full       (queue_full),
        .pop        (back_pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    // Back end: frame state machine with the registered result slot.
    ifr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_token    (head_token),
        .pop           (back_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .sequence_bit  (sequence_bit),
        .payload_count (payload_count)
    );

endmodule

// File: tb/info_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// info_frame_receiver_tb
// Self-checking regression for the byte-stuffed frame receiver. A short
// directed run covers the header, escape and verdict corner cases. Random
// frames then follow under several register settings, with idle gaps on both
// channels and one long output stall. Every output transaction is compared
// field by field against a cycle-free model of the deframer.
// ============================================================================
module info_frame_receiver_tb;

    import ifr_pkg::*;

    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 5;
    // The pipeline registers plus the two-entry input queue; rounded up generously.
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_ITEMS    = 200;
    localparam int STAGE_ITEMS     = 32;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int MAX_PRINTED     = 40;
    // Far above the slowest legal run.
    localparam longint WATCHDOG_NS = 64'd10_000_000;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Directed opening run, written for the reset register values
    // (flag 7E, escape 7D, address 03, control 00 / 40).
    localparam int OPENING_LEN = 31;
    localparam logic [0:OPENING_LEN-1][7:0] OPENING_RUN = {
        // Empty payload: a lone zero check byte is accepted with count zero.
        8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h7E,
        // Too short: header with sequence one, then the closing flag at once.
        8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E,
        // Payload FF and an escaped flag, check 81, then an escape dropped by
        // the closing flag.
        8'h7E, 8'h03, 8'h40, 8'h43, 8'hFF, 8'h7D, 8'h5E, 8'h81, 8'h7D, 8'h7E,
        // Repeated flag keeps waiting for the address; a wrong control byte
        // sends the receiver back to hunting.
        8'h7E, 8'h7E, 8'h03, 8'h55,
        // Check byte that does not match the empty running XOR: reject.
        8'h7E, 8'h03, 8'h00, 8'h03, 8'h01, 8'h7E
    };

    // One output transaction, packed in port order.
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data;
        logic               seq;
        logic [COUNT_W-1:0] count;
    } rx_event_t;

    // ------------------------------------------------------------------------
    // Deframer tracker: mirrors the registers and frame state, predicts the
    // output transactions of every accepted line byte and checks the ones
    // that come out of the block.
    // ------------------------------------------------------------------------
    class deframer_tracker;
        logic [7:0]         flag_byte;
        logic [7:0]         escape_byte;
        logic [7:0]         address_byte;
        logic [7:0]         ctrl_even;
        logic [7:0]         ctrl_odd;
        logic [2:0]         hunt_phase;
        logic               escape_armed;
        logic [7:0]         held_byte;
        logic               held_valid;
        logic [7:0]         frame_xor;
        logic [COUNT_W-1:0] delivered_count;
        logic               seq_now;
        rx_event_t          pending_events[$];
        int unsigned        error_count;
        int unsigned        event_count;

        function new();
            flag_byte    = 8'h7E;
            escape_byte  = 8'h7D;
            address_byte = 8'h03;
            ctrl_even    = 8'h00;
            ctrl_odd     = 8'h40;
            hunt_phase   = PH_HUNT;
            seq_now      = 1'b0;
            error_count  = 0;
            event_count  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            escape_armed    = 1'b0;
            held_byte       = ZERO_BYTE;
            held_valid      = 1'b0;
            frame_xor       = ZERO_BYTE;
            delivered_count = '0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] index,
                                   input logic [7:0] value);
            case (index)
                REG_FLAG:  flag_byte    = value;
                REG_ESC:   escape_byte  = value;
                REG_ADDR:  address_byte = value;
                REG_CTRL0: ctrl_even    = value;
                REG_CTRL1: ctrl_odd     = value;
                default:   ;
            endcase
        endfunction

        // Sequence and count are taken before any toggle or clear.
        function void queue_event(input logic [1:0] code, input logic [7:0] value);
            rx_event_t ev;
            ev.kind  = code;
            ev.data  = value;
            ev.seq   = seq_now;
            ev.count = delivered_count;
            pending_events.push_back(ev);
        endfunction

        function void take_line_byte(input logic [7:0] b);
            logic [7:0] ctrl;
            logic [7:0] value;
            ctrl = seq_now ? ctrl_odd : ctrl_even;
            case (hunt_phase)
                PH_HUNT:
                    if (b == flag_byte) hunt_phase = PH_GOT_FLAG;
                PH_GOT_FLAG:
                    if (b == address_byte) hunt_phase = PH_GOT_ADDR;
                    else if (b != flag_byte) hunt_phase = PH_HUNT;
                PH_GOT_ADDR:
                    if (b == ctrl) hunt_phase = PH_GOT_CTRL;
                    else if (b == flag_byte) hunt_phase = PH_GOT_FLAG;
                    else hunt_phase = PH_HUNT;
                PH_GOT_CTRL:
                    if (b == (address_byte ^ ctrl)) begin
                        hunt_phase = PH_DATA;
                        clear_frame();
                    end else if (b == flag_byte) begin
                        hunt_phase = PH_GOT_FLAG;
                    end else begin
                        hunt_phase = PH_HUNT;
                    end
                PH_DATA:
                    if (b == flag_byte) begin
                        // The flag always closes the frame, even after an escape.
                        if (!held_valid) begin
                            queue_event(KIND_LENGTH, ZERO_BYTE);
                        end else if (held_byte == frame_xor) begin
                            queue_event(KIND_ACCEPT, ZERO_BYTE);
                            seq_now = ~seq_now;
                        end else begin
                            queue_event(KIND_REJECT, ZERO_BYTE);
                        end
                        hunt_phase = PH_HUNT;
                        clear_frame();
                    end else if (!escape_armed && b == escape_byte) begin
                        escape_armed = 1'b1;
                    end else begin
                        value        = escape_armed ? (b ^ ESC_XOR) : b;
                        escape_armed = 1'b0;
                        if (!held_valid) begin
                            held_byte  = value;
                            held_valid = 1'b1;
                        end else if (delivered_count >= COUNT_LIMIT) begin
                            queue_event(KIND_LENGTH, ZERO_BYTE);
                            hunt_phase = PH_HUNT;
                            clear_frame();
                        end else begin
                            // Deliver the byte held back one step.
                            frame_xor       = frame_xor ^ held_byte;
                            delivered_count = delivered_count + 1'b1;
                            queue_event(KIND_PAYLOAD, held_byte);
                            held_byte = value;
                        end
                    end
                default:
                    hunt_phase = PH_HUNT;
            endcase
        endfunction

        task report(input string msg);
            if (error_count < MAX_PRINTED)
                $display("ERROR at %0t ns: %s", $time, msg);
            error_count++;
        endtask

        task match_result(input rx_event_t got);
            rx_event_t want;
            event_count++;
            if (pending_events.size() == 0) begin
                report($sformatf("output %0d arrived with nothing predicted (kind %0d)",
                                 event_count, got.kind));
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("output %0d: kind %0d, predicted %0d",
                                 event_count, got.kind, want.kind));
            if (got.data !== want.data)
                report($sformatf("output %0d: payload_byte %02h, predicted %02h",
                                 event_count, got.data, want.data));
            if (got.seq !== want.seq)
                report($sformatf("output %0d: sequence_bit %0b, predicted %0b",
                                 event_count, got.seq, want.seq));
            if (got.count !== want.count)
                report($sformatf("output %0d: payload_count %0d, predicted %0d",
                                 event_count, got.count, want.count));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [7:0]           line_byte = 8'h00;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FLAG;
    logic [7:0]           cfg_data  = 8'h00;
    logic                 in_ready;
    logic                 out_valid;
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic                 sequence_bit;
    logic [COUNT_W-1:0]   payload_count;
    logic                 cfg_ready;

    // Per-stage idling switches and the request for the long output stall.
    bit line_quiet  = 1'b0;
    bit sink_quiet  = 1'b0;
    bit squeeze_now = 1'b0;

    // Payload without flag or escape values, for the long frame.
    bit plain_payload = 1'b0;

    deframer_tracker tracker = new();

    // Line bytes of the exchange being built, sent in order.
    logic [7:0] burst[$];

    info_frame_receiver u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .line_byte     (line_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .sequence_bit  (sequence_bit),
        .payload_count (payload_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Helpers for idle gaps and frame construction.
    // ------------------------------------------------------------------------

    // Mostly back-to-back, often a short gap, now and then a long one.
    function automatic int pick_gap(input bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Payload content leans on the flag and escape values so that stuffing
    // shows up in most frames, unless a plain payload is asked for.
    function automatic logic [7:0] pick_payload_byte();
        int roll;
        logic [7:0] v;
        if (plain_payload) begin
            do v = 8'($urandom_range(0, 255));
            while (v == tracker.flag_byte || v == tracker.escape_byte);
            return v;
        end
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return tracker.flag_byte;
        if (roll < 4)
            return tracker.escape_byte;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_stuffed(input logic [7:0] v);
        if (v == tracker.flag_byte || v == tracker.escape_byte) begin
            burst.push_back(tracker.escape_byte);
            burst.push_back(v ^ ESC_XOR);
        end else begin
            burst.push_back(v);
        end
    endfunction

    // Opening flag, address, control and header check.
    function automatic void add_header(input logic [7:0] ctrl);
        burst.push_back(tracker.flag_byte);
        burst.push_back(tracker.address_byte);
        burst.push_back(ctrl);
        burst.push_back(tracker.address_byte ^ ctrl);
    endfunction

    // Stuffed payload, the XOR check (spoiled on request), an optional
    // dangling escape and the closing flag.
    function automatic void add_frame_body(input int len, input bit corrupt,
                                           input bit tail_escape);
        logic [7:0] v;
        logic [7:0] sum;
        sum = ZERO_BYTE;
        for (int i = 0; i < len; i++) begin
            v   = pick_payload_byte();
            sum = sum ^ v;
            add_stuffed(v);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        add_stuffed(sum);
        if (tail_escape)
            burst.push_back(tracker.escape_byte);
        burst.push_back(tracker.flag_byte);
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers. Valid is raised with the payload and held until the
    // transaction is taken; it is only lowered when a gap follows.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid  <= 1'b1;
        line_byte <= b;
        do @(posedge clk); while (!in_ready);
        tracker.take_line_byte(b);
        gap = pick_gap(line_quiet);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_burst();
        foreach (burst[i])
            send_byte(burst[i]);
        burst.delete();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(index, value);
    endtask

    // Writes the whole map; the spare indexes go last so that a write that
    // wrongly lands in a real register would show up in later frames.
    task automatic load_settings(input logic [7:0] flag, input logic [7:0] esc,
                                 input logic [7:0] addr, input logic [7:0] ctrl0,
                                 input logic [7:0] ctrl1, input bit poke_spare);
        write_register(REG_FLAG, flag);
        write_register(REG_ESC, esc);
        write_register(REG_ADDR, addr);
        write_register(REG_CTRL0, ctrl0);
        write_register(REG_CTRL1, ctrl1);
        if (poke_spare) begin
            write_register(REG_SPARE_LO, 8'($urandom_range(0, 255)));
            write_register(REG_SPARE_HI, 8'($urandom_range(0, 255)));
        end
        cfg_valid <= 1'b0;
    endtask

    // The sender stops until every predicted output has come, then lets the
    // pipeline empty bytes that give no output.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready comes in random runs, and once, on request, is held
    // low for a long stretch so the input queue fills and in_ready drops.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        bit squeezed;
        squeezed = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_now && !squeezed) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                squeezed = 1'b1;
            end
            out_ready <= 1'b1;
            repeat (sink_quiet ? 16 : $urandom_range(1, 12)) @(posedge clk);
            gap = pick_gap(sink_quiet);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Every output transaction is checked at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_result({kind, payload_byte, sequence_bit, payload_count});
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int         counted;
        int         stage;
        int         pick;
        int         pos;
        int         len;
        logic [7:0] ctrl_ok;
        logic [7:0] ctrl_other;
        logic [7:0] flag;
        logic [7:0] esc;
        logic [7:0] hdr[4];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases under the reset register values.
        for (int i = 0; i < OPENING_LEN; i++)
            burst.push_back(OPENING_RUN[i]);
        send_burst();

        // Random frames. Each stage starts from an idle block with new
        // register values; stage 0 keeps the reset values.
        counted = 0;
        stage   = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= (stage + 1) * STAGE_ITEMS) begin
                stage++;
                wait_drained();
                case (stage)
                    // All-zeros and all-ones extremes, in both arrangements.
                    1: load_settings(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1);
                    2: load_settings(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
                    5: load_settings(8'h7E, 8'h7D, 8'h03, 8'h00, 8'h40, 1'b1);
                    default:
                    begin
                        // Escaping must stay possible: the escape differs from
                        // the flag, and so does its stuffed form.
                        flag = 8'($urandom_range(0, 255));
                        do esc = 8'($urandom_range(0, 255));
                        while (esc == flag || (esc ^ ESC_XOR) == flag);
                        load_settings(flag, esc, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 1'b0);
                    end
                endcase
                // The long output stall runs while the sender keeps offering.
                if (stage == 2)
                    squeeze_now = 1'b1;
                line_quiet = ($urandom_range(0, 3) == 0);
                sink_quiet = ($urandom_range(0, 3) == 0);
            end

            ctrl_ok    = tracker.seq_now ? tracker.ctrl_odd : tracker.ctrl_even;
            ctrl_other = tracker.seq_now ? tracker.ctrl_even : tracker.ctrl_odd;
            len        = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(0, 8);
            // Now and then a spare flag ahead of the exchange.
            if ($urandom_range(0, 7) == 0)
                burst.push_back(tracker.flag_byte);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                add_header(ctrl_ok);
                add_frame_body(len, 1'b0, 1'b0);
            end else if (pick < 60) begin
                add_header(ctrl_ok);
                add_frame_body(len, 1'b1, 1'b0);
            end else if (pick < 65) begin
                // Escape left pending when the closing flag arrives.
                add_header(ctrl_ok);
                add_frame_body(len, 1'b0, 1'b1);
            end else if (pick < 70) begin
                // Too short: no check byte before the flag.
                add_header(ctrl_ok);
                if ($urandom_range(0, 1) == 1)
                    burst.push_back(tracker.escape_byte);
                burst.push_back(tracker.flag_byte);
            end else if (pick < 78) begin
                // Retransmission carrying the other sequence's control byte.
                add_header(ctrl_other);
                add_frame_body(len, 1'b0, 1'b0);
            end else if (pick < 90) begin
                // Header cut short by a stray byte or a flag, often followed
                // by a proper frame.
                hdr[0] = tracker.flag_byte;
                hdr[1] = tracker.address_byte;
                hdr[2] = ctrl_ok;
                hdr[3] = tracker.address_byte ^ ctrl_ok;
                pos    = $urandom_range(1, 3);
                hdr[pos] = ($urandom_range(0, 1) == 1) ? tracker.flag_byte
                                                        : 8'($urandom_range(0, 255));
                for (int i = 0; i <= pos; i++)
                    burst.push_back(hdr[i]);
                if ($urandom_range(0, 1) == 1) begin
                    add_header(ctrl_ok);
                    add_frame_body(len, 1'b0, 1'b0);
                end
            end else begin
                // Line noise between frames; most of it is simply ignored.
                repeat ($urandom_range(1, 6))
                    burst.push_back(8'($urandom_range(0, 255)));
                counted += burst.size();
                send_burst();
                continue;
            end
            counted += burst.size();
            send_burst();
        end

        // Payload length limit: one byte beyond the maximum gives a length
        // error at the check byte, and a short frame then proves recovery.
        // The long frame carries no stuffing so that it stays short.
        wait_drained();
        plain_payload = 1'b1;
        add_header(tracker.seq_now ? tracker.ctrl_odd : tracker.ctrl_even);
        add_frame_body(MAX_PAYLOAD + 1, 1'b0, 1'b0);
        plain_payload = 1'b0;
        send_burst();
        add_header(tracker.seq_now ? tracker.ctrl_odd : tracker.ctrl_even);
        add_frame_body(3, 1'b0, 1'b0);
        send_burst();

        // Let every predicted output arrive, then give the pipeline time to
        // show any output that was never predicted.
        in_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && tracker.pending_events.size() != 0; n++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_events.size() != 0)
            tracker.report($sformatf("%0d predicted outputs never arrived",
                                     tracker.pending_events.size()));

        if (tracker.error_count == 0)
            $display("info_frame_receiver regression: pass");
        else
            $display("info_frame_receiver regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #WATCHDOG_NS;
        $display("info_frame_receiver regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/ifr_pkg.sv
hdl/ifr_front.sv
hdl/ifr_queue.sv
hdl/ifr_back.sv
hdl/info_frame_receiver.sv
tb/info_frame_receiver_tb.sv
